// ----- rtl/nfps_pkg.sv -----
// Package for the nearest four point selector.
// Shared sizes, register indexes and the control/status bundles.
// No dependencies.
package nfps_pkg;

    // number of kept entries and derived widths
    localparam int KEEP_COUNT = 4;
    localparam int SLOT_W     = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int CNT_W      = $clog2(KEEP_COUNT + 1);

    // field widths
    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 42;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the request
        logic diff;       // absolute axis differences
        logic square;     // axis squares
        logic sum;        // total distance, start farthest search
        logic scan;       // one step of the farthest search
        logic update;     // fill or replace a slot
        logic emit;       // present one kept entry
    } nfps_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;       // every slot holds an entry
        logic scan_done;  // farthest search on its final step
        logic last;       // request carried last_light
        logic emit_final; // entry being presented is the final one
    } nfps_stat_t;

endpackage

// ----- rtl/nfps_ctrl.sv -----
// Controller state machine for the nearest four point selector.
// Sequences one request through the datapath and the emission of kept entries.
// Depends on nfps_pkg.
module nfps_ctrl
    import nfps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  nfps_stat_t stat,
    output nfps_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_FAR  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                if (stat.full && (KEEP_COUNT > 1))
                    state_next = S_FAR;
                else
                    state_next = S_UPD;
            end
            S_FAR:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_final)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/nfps_dpath.sv -----
// Datapath for the nearest four point selector: query registers, distance
// arithmetic, kept slots, farthest search and result registers.
// Depends on nfps_pkg.
module nfps_dpath
    import nfps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  nfps_cmd_t                 cmd,
    output nfps_stat_t                stat,
    // request payload
    input  logic [INDEX_W-1:0]        light_index,
    input  logic signed [COORD_W-1:0] light_x,
    input  logic signed [COORD_W-1:0] light_y,
    input  logic signed [COORD_W-1:0] light_z,
    input  logic                      last_light,
    // configuration write
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [COORD_W-1:0] cfg_data,
    // results
    output logic                      result_valid,
    output logic [1:0]                result_slot,
    output logic [INDEX_W-1:0]        nearest_index,
    output logic [DIST_W-1:0]         distance_sq,
    output logic                      last_result
);

    // query point
    logic signed [COORD_W-1:0] qx_reg, qy_reg, qz_reg;

    // captured request
    logic [INDEX_W-1:0]        idx_reg;
    logic signed [COORD_W-1:0] lx_reg, ly_reg, lz_reg;
    logic                      last_reg;

    // arithmetic stages
    logic [DIFF_W-1:0]  adx_reg, ady_reg, adz_reg;
    logic [DIFF_W-1:0]  adx_next, ady_next, adz_next;
    logic [DIST_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]  sqx_next, sqy_next, sqz_next;
    logic [DIST_W-1:0]  dist_reg;

    // kept slots
    logic [DIST_W-1:0]  kept_dist_reg [KEEP_COUNT];
    logic [INDEX_W-1:0] kept_idx_reg  [KEEP_COUNT];
    logic [CNT_W-1:0]   count_reg;

    // farthest search and emission pointers
    logic [SLOT_W-1:0]  far_reg;
    logic [DIST_W-1:0]  far_dist_reg;
    logic [SLOT_W-1:0]  scan_reg;
    logic [SLOT_W-1:0]  emit_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic [DIST_W-1:0]  rd_dist;
    logic [INDEX_W-1:0] rd_idx;
    logic               full;
    logic               emit_final;

    // output registers
    logic               out_valid_reg;
    logic [1:0]         out_slot_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_last_reg;

    // absolute differences, one 21-bit subtract per axis
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    assign adx_next = abs_diff(lx_reg, qx_reg);
    assign ady_next = abs_diff(ly_reg, qy_reg);
    assign adz_next = abs_diff(lz_reg, qz_reg);

    // one 21x21 multiplier per axis, operands zero-extended to the result width
    assign sqx_next = DIST_W'(adx_reg) * DIST_W'(adx_reg);
    assign sqy_next = DIST_W'(ady_reg) * DIST_W'(ady_reg);
    assign sqz_next = DIST_W'(adz_reg) * DIST_W'(adz_reg);

    // read of the slots shared by the farthest search and the emission
    assign rd_addr    = cmd.emit ? emit_reg : scan_reg;
    assign rd_dist    = kept_dist_reg[rd_addr];
    assign rd_idx     = kept_idx_reg[rd_addr];

    assign full       = (count_reg == CNT_W'(KEEP_COUNT));
    assign emit_final = ((CNT_W'(emit_reg) + CNT_W'(1)) == count_reg);

    assign stat.full       = full;
    assign stat.scan_done  = (scan_reg == SLOT_W'(KEEP_COUNT - 1));
    assign stat.last       = last_reg;
    assign stat.emit_final = emit_final;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUERY_X: qx_reg <= cfg_data;
                CFG_QUERY_Y: qy_reg <= cfg_data;
                CFG_QUERY_Z: qz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request capture and arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg  <= light_index;
            lx_reg   <= light_x;
            ly_reg   <= light_y;
            lz_reg   <= light_z;
            last_reg <= last_light;
        end
        if (cmd.diff)
        begin
            adx_reg <= adx_next;
            ady_reg <= ady_next;
            adz_reg <= adz_next;
        end
        if (cmd.square)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
        end
        if (cmd.sum)
            dist_reg <= sqx_reg + sqy_reg + sqz_reg;
    end

    // farthest search: lowest slot wins ties, one slot per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            far_reg      <= '0;
            far_dist_reg <= kept_dist_reg[0];
            scan_reg     <= SLOT_W'(1);
        end
        else if (cmd.scan)
        begin
            if (rd_dist > far_dist_reg)
            begin
                far_reg      <= scan_reg;
                far_dist_reg <= rd_dist;
            end
            scan_reg <= scan_reg + SLOT_W'(1);
        end
    end

    // slot contents: fill in arrival order, then replace farthest if strictly nearer
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (!full)
            begin
                kept_dist_reg[count_reg[SLOT_W-1:0]] <= dist_reg;
                kept_idx_reg[count_reg[SLOT_W-1:0]]  <= idx_reg;
            end
            else if (dist_reg < far_dist_reg)
            begin
                kept_dist_reg[far_reg] <= dist_reg;
                kept_idx_reg[far_reg]  <= idx_reg;
            end
        end
    end

    // fill count and emission pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            emit_reg  <= '0;
        end
        else if (cmd.update && !full)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (cmd.emit)
        begin
            if (emit_final)
            begin
                count_reg <= '0;
                emit_reg  <= '0;
            end
            else
            begin
                emit_reg <= emit_reg + SLOT_W'(1);
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= cmd.emit;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_slot_reg <= 2'(emit_reg);
            out_idx_reg  <= rd_idx;
            out_dist_reg <= rd_dist;
            out_last_reg <= emit_final;
        end
    end

    assign result_valid  = out_valid_reg;
    assign result_slot   = out_slot_reg;
    assign nearest_index = out_idx_reg;
    assign distance_sq   = out_dist_reg;
    assign last_result   = out_last_reg;

    // fill count stays within the slot count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(KEEP_COUNT))
        else $error("fill count beyond slot count");

    // final result of a set leaves the count cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (count_reg == '0))
        else $error("count not cleared after final result");

    // results of one set come back to back in slot order
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |=>
            (out_valid_reg && (out_slot_reg == $past(out_slot_reg) + 2'd1)))
        else $error("emission out of slot order");

    // no fill or replace while results are being presented
    a_no_update_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.update))
        else $error("slot update during emission");

endmodule

// ----- rtl/nearest_four_point_select_core.sv -----
// Nearest four point selector, top level.
// Joins nfps_ctrl and nfps_dpath; depends on nfps_pkg.
//
// Usage:
//   Requests: drive light_index, light_x/y/z and last_light with start high;
//   the request is taken at an edge where start is high and busy is low.
//   Squared distance to the query point is formed through the difference,
//   square and sum registers in turn, then the kept slots are updated.
//   While all slots are full a farthest search walks the slots one per
//   cycle before the update. busy stays high from the taken request
//   through the update; with start held, the next request is taken only
//   after busy has dropped again.
//   Results: on a request with last_light set, each kept entry is presented
//   in slot order, one per cycle, with result_valid high for one cycle;
//   last_result marks the final one. Each result is registered before its
//   strobe, and busy stays high until the final kept entry has been
//   emitted. The receiver cannot stall: every strobed result is taken.
//   Configuration: cfg_valid/cfg_ready write query_x/y/z (index 0..2);
//   cfg_ready is always high, other indexes are ignored. Write only while idle.
//   Reset: clears the query point to zero and empties the slots.
module nearest_four_point_select_core
    import nfps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      start,
    output logic                      busy,
    input  logic [INDEX_W-1:0]        light_index,
    input  logic signed [COORD_W-1:0] light_x,
    input  logic signed [COORD_W-1:0] light_y,
    input  logic signed [COORD_W-1:0] light_z,
    input  logic                      last_light,
    // configuration channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [COORD_W-1:0] cfg_data,
    // result channel
    output logic                      result_valid,
    output logic [1:0]                result_slot,
    output logic [INDEX_W-1:0]        nearest_index,
    output logic [DIST_W-1:0]         distance_sq,
    output logic                      last_result
);

    nfps_cmd_t  cmd;
    nfps_stat_t stat;

    assign cfg_ready = 1'b1;

    nfps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    nfps_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .light_index   (light_index),
        .light_x       (light_x),
        .light_y       (light_y),
        .light_z       (light_z),
        .last_light    (last_light),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .result_slot   (result_slot),
        .nearest_index (nearest_index),
        .distance_sq   (distance_sq),
        .last_result   (last_result)
    );

endmodule
